### rtl/mpls_label_stack_decapsulator_macros.svh
// Assertion macros for the MPLS label stack decapsulator.
`ifndef MPLS_LABEL_STACK_DECAPSULATOR_MACROS_SVH
`define MPLS_LABEL_STACK_DECAPSULATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define MLSD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define MLSD_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define MLSD_ASSERT(lbl, clk, rstn, prop, msg)
`define MLSD_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

### rtl/mlsd_pkg.sv
`timescale 1ns / 1ps

package mlsd_pkg;

    localparam int MAX_LABELS  = 8;
    localparam int ETH_HDR_LEN = 14;
    localparam int HDR_DEPTH   = ETH_HDR_LEN + 4 * MAX_LABELS;
    localparam int POS_W       = $clog2(HDR_DEPTH + 1);
    localparam int ADDR_W      = $clog2(HDR_DEPTH);

    localparam logic [15:0] ETHERTYPE_MPLS_UC = 16'h8847;
    localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
    localparam logic [31:0] LABEL_BOS_MASK    = 32'h0000_0100;

    typedef logic [1:0] verdict_t;

    localparam verdict_t V_DECAP    = 2'd0;
    localparam verdict_t V_IGNORED  = 2'd1;
    localparam verdict_t V_MAL_PASS = 2'd2;
    localparam verdict_t V_MAL_DROP = 2'd3;

endpackage

### rtl/mpls_label_stack_decapsulator.sv
`timescale 1ns / 1ps

// MPLS label stack decapsulator. Takes an Ethernet frame one byte per transaction and holds
// back its header in a header memory until it can decide. A frame whose ethertype is not
// MPLS unicast passes unchanged with verdict ignored; an MPLS frame loses its whole label
// stack, gets ethertype IPv4 and then passes its payload with verdict decapsulated. A frame
// that ends early or reaches MAX_LABELS labels without a bottom of stack is malformed and
// is passed unchanged with verdict 2, or 3 when strict drop is configured. The verdict
// travels in m_tuser on the last byte and is zero elsewhere. Once the decision falls the
// held bytes drain from the single read port of the header memory at one byte per cycle
// while the output is not stalled (up to 14 + 4 * MAX_LABELS of them), and the input
// stalls until the drain is done. Payload bytes after the header then pass at one byte
// per cycle while the output is free, each leaving in the cycle after it is accepted.
module mpls_label_stack_decapsulator
    import mlsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,   // strict_drop
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // data_byte[7:0]
    input  logic       s_tlast,       // frame_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // out_byte[7:0]
    output logic       m_tlast,       // out_end
    output logic [1:0] m_tuser        // verdict[1:0]
);

`include "mpls_label_stack_decapsulator_macros.svh"

    typedef enum logic [1:0] {
        PH_ETH,
        PH_LABEL,
        PH_PASS
    } phase_t;

    logic [7:0]       hdr_mem [HDR_DEPTH];

    phase_t           phase_reg;
    logic [POS_W-1:0] pos_reg;
    verdict_t         frame_verdict_reg;
    logic             strict_reg;
    logic [7:0]       et_hi_reg;
    logic             sbit_reg;

    logic             flushing_reg;
    logic [POS_W-1:0] flush_idx_reg;
    logic [POS_W-1:0] flush_cnt_reg;
    logic             flush_end_reg;
    logic             flush_decap_reg;
    verdict_t         flush_verdict_reg;

    logic             rd_valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_last_reg;
    logic             rd_hi_reg;
    logic             rd_lo_reg;

    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic             m_last_reg;
    verdict_t         m_user_reg;

    logic             out_free;
    logic             rd_move;
    logic             rd_free;
    logic             issue;
    logic             issue_last;
    logic             s_accept;
    logic             hdr_accept;
    logic             pass_accept;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] lbl_off;
    verdict_t         mal_code;
    logic [7:0]       rd_byte;

    logic             do_flush;
    logic [POS_W-1:0] fl_cnt;
    verdict_t         fl_verdict;
    logic             fl_decap;

    assign out_free    = !m_valid_reg || m_tready;
    assign rd_move     = rd_valid_reg && out_free;
    assign rd_free     = !rd_valid_reg || rd_move;
    assign issue       = flushing_reg && rd_free;
    assign issue_last  = flush_idx_reg == flush_cnt_reg - POS_W'(1);

    assign s_tready    = !flushing_reg && !rd_valid_reg &&
                         ((phase_reg != PH_PASS) || out_free);
    assign s_accept    = s_tvalid && s_tready;
    assign hdr_accept  = s_accept && (phase_reg != PH_PASS);
    assign pass_accept = s_accept && (phase_reg == PH_PASS);

    assign pos_next    = pos_reg + POS_W'(1);
    assign lbl_off     = pos_reg - POS_W'(ETH_HDR_LEN);
    assign mal_code    = strict_reg ? V_MAL_DROP : V_MAL_PASS;

    assign rd_byte     = rd_hi_reg ? ETHERTYPE_IPV4[15:8] :
                         rd_lo_reg ? ETHERTYPE_IPV4[7:0]  : rd_data_reg;

    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_data_reg;
    assign m_tlast     = m_last_reg;
    assign m_tuser     = m_user_reg;

    // Decide on a held header byte.
    always_comb begin
        do_flush   = 1'b0;
        fl_cnt     = pos_next;
        fl_verdict = mal_code;
        fl_decap   = 1'b0;
        if (phase_reg == PH_LABEL) begin
            if (lbl_off[1:0] == 2'd3) begin
                if (sbit_reg) begin
                    do_flush   = 1'b1;
                    fl_cnt     = POS_W'(ETH_HDR_LEN);
                    fl_verdict = V_DECAP;
                    fl_decap   = 1'b1;
                end else if (pos_next == POS_W'(HDR_DEPTH) || s_tlast) begin
                    do_flush = 1'b1;
                end
            end else if (s_tlast) begin
                do_flush = 1'b1;
            end
        end else begin
            if (pos_next < POS_W'(ETH_HDR_LEN)) begin
                do_flush = s_tlast;
            end else if ({et_hi_reg, s_tdata} != ETHERTYPE_MPLS_UC) begin
                do_flush   = 1'b1;
                fl_verdict = V_IGNORED;
            end else begin
                do_flush = s_tlast;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hdr_accept) begin
            hdr_mem[pos_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (issue) begin
            rd_data_reg <= hdr_mem[flush_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_ETH;
            pos_reg           <= '0;
            frame_verdict_reg <= V_DECAP;
            strict_reg        <= 1'b0;
            flushing_reg      <= 1'b0;
            rd_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                strict_reg <= cfg_wr_data;
            end

            if (hdr_accept) begin
                if (pos_reg == POS_W'(ETH_HDR_LEN - 2)) begin
                    et_hi_reg <= s_tdata;
                end
                if (phase_reg == PH_LABEL && lbl_off[1:0] == 2'd2) begin
                    sbit_reg <= |(s_tdata & LABEL_BOS_MASK[15:8]);
                end
                if (do_flush) begin
                    pos_reg           <= '0;
                    flushing_reg      <= 1'b1;
                    flush_idx_reg     <= '0;
                    flush_cnt_reg     <= fl_cnt;
                    flush_end_reg     <= s_tlast;
                    flush_decap_reg   <= fl_decap;
                    flush_verdict_reg <= fl_verdict;
                    if (s_tlast) begin
                        phase_reg         <= PH_ETH;
                        frame_verdict_reg <= V_DECAP;
                    end else begin
                        phase_reg         <= PH_PASS;
                        frame_verdict_reg <= fl_verdict;
                    end
                end else begin
                    pos_reg <= pos_next;
                    if (pos_next == POS_W'(ETH_HDR_LEN)) begin
                        phase_reg <= PH_LABEL;
                    end
                end
            end

            if (issue) begin
                flush_idx_reg <= flush_idx_reg + POS_W'(1);
                rd_last_reg   <= flush_end_reg && issue_last;
                rd_hi_reg     <= flush_decap_reg &&
                                 flush_idx_reg == POS_W'(ETH_HDR_LEN - 2);
                rd_lo_reg     <= flush_decap_reg &&
                                 flush_idx_reg == POS_W'(ETH_HDR_LEN - 1);
                if (issue_last) begin
                    flushing_reg <= 1'b0;
                end
            end
            if (issue) begin
                rd_valid_reg <= 1'b1;
            end else if (rd_move) begin
                rd_valid_reg <= 1'b0;
            end

            if (rd_move) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= rd_byte;
                m_last_reg  <= rd_last_reg;
                m_user_reg  <= rd_last_reg ? flush_verdict_reg : V_DECAP;
            end else if (pass_accept) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= s_tdata;
                m_last_reg  <= s_tlast;
                m_user_reg  <= s_tlast ? frame_verdict_reg : V_DECAP;
                if (s_tlast) begin
                    phase_reg         <= PH_ETH;
                    frame_verdict_reg <= V_DECAP;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `MLSD_NEVER(a_no_input_in_flush, aclk, aresetn, s_accept && flushing_reg, "input during flush")
    `MLSD_ASSERT(a_issue_in_range, aclk, aresetn, issue |-> flush_idx_reg < flush_cnt_reg, "flush overrun")
    `MLSD_ASSERT(a_pos_in_range, aclk, aresetn, pos_reg < POS_W'(HDR_DEPTH), "header position overflow")
    `MLSD_ASSERT(a_pass_pos_zero, aclk, aresetn, phase_reg == PH_PASS |-> pos_reg == '0, "position kept in pass")
    `MLSD_ASSERT(a_last_ends_flush, aclk, aresetn, (rd_valid_reg && rd_last_reg) |-> !flushing_reg, "flush past last byte")

endmodule
